>>> rtl/core/pidc_pkg.sv
package pidc_pkg;

    // Fixed field widths
    localparam int KIND_W     = 2;
    localparam int GOAL_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 24;
    localparam int INTEG_W    = LIMIT_W + 1;
    localparam int BAND_W     = 16;
    localparam int MODE_W     = 2;
    localparam int CMD_W      = 32;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // Input word kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_ENABLE  = 2'd1,
        KIND_DISABLE = 2'd2
    } kind_t;

    // Goal band handling
    typedef enum logic [MODE_W-1:0] {
        MODE_ALWAYS = 2'd0,
        MODE_SKIP   = 2'd1,
        MODE_STOP   = 2'd2
    } goal_mode_t;

    // Register indexes of the configuration port
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GOAL       = 3'd0,
        REG_GAIN_P     = 3'd1,
        REG_GAIN_I_DT  = 3'd2,
        REG_GAIN_D_DT  = 3'd3,
        REG_INT_LIMIT  = 3'd4,
        REG_GOAL_BAND  = 3'd5,
        REG_GOAL_MODE  = 3'd6
    } cfg_reg_t;

    // Status carried alongside each word through the pipeline
    typedef struct packed {
        logic cmd_valid;
        logic at_goal;
        logic running;
    } flags_t;

endpackage

>>> rtl/core/pidc_err.sv
module pidc_err #(
    parameter int SAMPLE_BITS = 16,
    localparam int ERR_W = ((SAMPLE_BITS > pidc_pkg::GOAL_W) ? SAMPLE_BITS
                                                              : pidc_pkg::GOAL_W) + 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [pidc_pkg::KIND_W-1:0]         kind,
    input  logic signed [SAMPLE_BITS-1:0]       measurement,
    input  logic signed [pidc_pkg::GOAL_W-1:0]  goal,
    input  logic [pidc_pkg::LIMIT_W-1:0]        integral_limit,
    input  logic [pidc_pkg::BAND_W-1:0]         goal_band,
    input  logic [pidc_pkg::MODE_W-1:0]         goal_mode,
    output logic signed [ERR_W-1:0]             err_q,
    output logic signed [pidc_pkg::INTEG_W-1:0] isum_q,
    output logic signed [ERR_W:0]               diff_q,
    output pidc_pkg::flags_t                    flags_q
);
    import pidc_pkg::*;

    localparam int SUM_W = ((INTEG_W > ERR_W) ? INTEG_W : ERR_W) + 1;

    logic signed [INTEG_W-1:0] error_sum_reg, error_sum_next;
    logic signed [ERR_W-1:0]   last_error_reg, last_error_next;
    logic                      enabled_reg, enabled_next;
    logic                      goal_reg, goal_next;

    logic signed [ERR_W-1:0]   err;
    logic [ERR_W-1:0]          err_mag;
    logic                      in_band;
    logic signed [SUM_W-1:0]   sum_raw;
    logic signed [SUM_W-1:0]   lim_pos;
    logic signed [SUM_W-1:0]   lim_neg;
    logic signed [INTEG_W-1:0] sum_clamped;
    logic signed [ERR_W:0]     diff;
    logic                      fire;

    // Error, band test and clamped integral
    assign err     = ERR_W'(goal) - ERR_W'(measurement);
    assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    assign in_band = err_mag < ERR_W'(goal_band);
    assign sum_raw = SUM_W'(error_sum_reg) + SUM_W'(err);
    assign lim_pos = $signed({{(SUM_W-LIMIT_W){1'b0}}, integral_limit});
    assign lim_neg = -lim_pos;
    assign diff    = (ERR_W+1)'(err) - (ERR_W+1)'(last_error_reg);

    always_comb
    begin
        if (sum_raw > lim_pos)
        begin
            sum_clamped = INTEG_W'(lim_pos);
        end
        else if (sum_raw < lim_neg)
        begin
            sum_clamped = INTEG_W'(lim_neg);
        end
        else
        begin
            sum_clamped = INTEG_W'(sum_raw);
        end
    end

    // Decide the state change for this word
    always_comb
    begin
        error_sum_next  = error_sum_reg;
        last_error_next = last_error_reg;
        enabled_next    = enabled_reg;
        goal_next       = goal_reg;
        fire            = 1'b0;
        case (kind)
            KIND_ENABLE:
            begin
                enabled_next    = 1'b1;
                goal_next       = 1'b0;
                error_sum_next  = '0;
                last_error_next = '0;
            end
            KIND_DISABLE:
            begin
                enabled_next = 1'b0;
            end
            KIND_SAMPLE:
            begin
                if (enabled_reg)
                begin
                    if (goal_mode == MODE_ALWAYS || !in_band)
                    begin
                        fire            = 1'b1;
                        error_sum_next  = sum_clamped;
                        last_error_next = err;
                    end
                    else if (goal_mode != MODE_SKIP)
                    begin
                        // stop at goal
                        goal_next    = 1'b1;
                        enabled_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            enabled_reg    <= 1'b0;
            goal_reg       <= 1'b0;
        end
        else if (step)
        begin
            error_sum_reg  <= error_sum_next;
            last_error_reg <= last_error_next;
            enabled_reg    <= enabled_next;
            goal_reg       <= goal_next;
        end
    end

    // Stage register toward the multipliers
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            err_q             <= err;
            isum_q            <= error_sum_next;
            diff_q            <= diff;
            flags_q.cmd_valid <= fire;
            flags_q.at_goal   <= goal_next;
            flags_q.running   <= enabled_next;
        end
    end

endmodule

>>> rtl/core/pidc_mac.sv
module pidc_mac #(
    parameter int SAMPLE_BITS    = 16,
    parameter int GAIN_FRAC_BITS = 8,
    localparam int ERR_W = ((SAMPLE_BITS > pidc_pkg::GOAL_W) ? SAMPLE_BITS
                                                              : pidc_pkg::GOAL_W) + 1
) (
    input  logic                                clk,
    input  logic                                load_prod,
    input  logic                                load_out,
    input  logic signed [pidc_pkg::GAIN_W-1:0]  gain_p,
    input  logic signed [pidc_pkg::GAIN_W-1:0]  gain_i_dt,
    input  logic signed [pidc_pkg::GAIN_W-1:0]  gain_d_per_dt,
    input  logic signed [ERR_W-1:0]             err,
    input  logic signed [pidc_pkg::INTEG_W-1:0] isum,
    input  logic signed [ERR_W:0]               diff,
    input  pidc_pkg::flags_t                    flags_in,
    output logic signed [pidc_pkg::CMD_W-1:0]   command,
    output pidc_pkg::flags_t                    flags_out
);
    import pidc_pkg::*;

    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int PI_W  = GAIN_W + INTEG_W;
    localparam int PD_W  = GAIN_W + ERR_W + 1;
    localparam int PM_W  = (PI_W > PD_W) ? PI_W : PD_W;
    localparam int ACC_A = PM_W + 2;
    localparam int ACC_B = CMD_W + 1 + GAIN_FRAC_BITS;
    localparam int ACC_W = (ACC_A > ACC_B) ? ACC_A : ACC_B;
    localparam int HI_W  = ACC_W - CMD_W + 1;

    logic signed [PP_W-1:0]  prod_p_reg;
    logic signed [PI_W-1:0]  prod_i_reg;
    logic signed [PD_W-1:0]  prod_d_reg;
    flags_t                  flags_mid_reg;

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] scaled;
    logic [HI_W-1:0]         scaled_hi;
    logic signed [CMD_W-1:0] sat;

    // Three gain products
    always_ff @(posedge clk)
    begin
        if (load_prod)
        begin
            prod_p_reg    <= PP_W'(gain_p) * PP_W'(err);
            prod_i_reg    <= PI_W'(gain_i_dt) * PI_W'(isum);
            prod_d_reg    <= PD_W'(gain_d_per_dt) * PD_W'(diff);
            flags_mid_reg <= flags_in;
        end
    end

    // Sum, drop the gain fraction (floor), saturate to the command range
    assign acc       = ACC_W'(prod_p_reg) + ACC_W'(prod_i_reg) + ACC_W'(prod_d_reg);
    assign scaled    = acc >>> GAIN_FRAC_BITS;
    assign scaled_hi = scaled[ACC_W-1:CMD_W-1];

    always_comb
    begin
        if ((&scaled_hi) || !(|scaled_hi))
        begin
            sat = scaled[CMD_W-1:0];
        end
        else if (scaled[ACC_W-1])
        begin
            sat = {1'b1, {(CMD_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(CMD_W-1){1'b1}}};
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            command   <= flags_mid_reg.cmd_valid ? sat : '0;
            flags_out <= flags_mid_reg;
        end
    end

endmodule

>>> rtl/core/pid_controller_step_top.sv
// PID step controller with clamped integral.
// Each accepted word passes through the input, error, product and result registers before
// its result word is valid on the master side. Integral and previous error update together.
// Throughput: one word per cycle while m_axis_tready does not stall the pipeline.
// Reset (rst_n low, asynchronous): pipeline emptied, controller stopped, integral and
// previous error cleared, configuration registers 0 except integral_limit, which resets to all ones.
module pid_controller_step_top #(
    parameter int SAMPLE_BITS    = 16,
    parameter int GAIN_FRAC_BITS = 8,
    localparam int IN_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [pidc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [IN_DATA_W-1:0]               s_axis_tdata,   // measurement
    input  logic [pidc_pkg::KIND_W-1:0]        s_axis_tuser,   // kind
    // master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pidc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // command, at_goal, running
    output logic                               m_axis_tuser    // command_valid
);
    import pidc_pkg::*;

    localparam int ERR_W = ((SAMPLE_BITS > GOAL_W) ? SAMPLE_BITS : GOAL_W) + 1;

    logic signed [GOAL_W-1:0] goal_reg;
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_dt_reg;
    logic signed [GAIN_W-1:0] gain_d_dt_reg;
    logic [LIMIT_W-1:0]       int_limit_reg;
    logic [BAND_W-1:0]        goal_band_reg;
    logic [MODE_W-1:0]        goal_mode_reg;

    logic [KIND_W-1:0]           kind_reg;
    logic signed [SAMPLE_BITS-1:0] meas_reg;

    logic vld0_reg, vld1_reg, vld2_reg, vld3_reg;
    logic rdy0, rdy1, rdy2, rdy3;

    logic signed [ERR_W-1:0]   err_s1;
    logic signed [INTEG_W-1:0] isum_s1;
    logic signed [ERR_W:0]     diff_s1;
    flags_t                    flags_s1;
    logic signed [CMD_W-1:0]   command;
    flags_t                    flags_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg      <= '0;
            gain_p_reg    <= '0;
            gain_i_dt_reg <= '0;
            gain_d_dt_reg <= '0;
            int_limit_reg <= '1;
            goal_band_reg <= '0;
            goal_mode_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GOAL:      goal_reg      <= cfg_wdata[GOAL_W-1:0];
                REG_GAIN_P:    gain_p_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I_DT: gain_i_dt_reg <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D_DT: gain_d_dt_reg <= cfg_wdata[GAIN_W-1:0];
                REG_INT_LIMIT: int_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_GOAL_BAND: goal_band_reg <= cfg_wdata[BAND_W-1:0];
                REG_GOAL_MODE: goal_mode_reg <= cfg_wdata[MODE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Pipeline flow control: a stage loads when empty or when it drains
    assign rdy3 = !vld3_reg || m_axis_tready;
    assign rdy2 = !vld2_reg || rdy3;
    assign rdy1 = !vld1_reg || rdy2;
    assign rdy0 = !vld0_reg || rdy1;

    assign s_axis_tready = rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                vld0_reg <= s_axis_tvalid;
            end
            if (rdy1)
            begin
                vld1_reg <= vld0_reg;
            end
            if (rdy2)
            begin
                vld2_reg <= vld1_reg;
            end
            if (rdy3)
            begin
                vld3_reg <= vld2_reg;
            end
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (rdy0 && s_axis_tvalid)
        begin
            kind_reg <= s_axis_tuser;
            meas_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    // Error, integral and controller state
    pidc_err #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_err (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (rdy1 && vld0_reg),
        .kind           (kind_reg),
        .measurement    (meas_reg),
        .goal           (goal_reg),
        .integral_limit (int_limit_reg),
        .goal_band      (goal_band_reg),
        .goal_mode      (goal_mode_reg),
        .err_q          (err_s1),
        .isum_q         (isum_s1),
        .diff_q         (diff_s1),
        .flags_q        (flags_s1)
    );

    // Gain products and saturated command
    pidc_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mac (
        .clk           (clk),
        .load_prod     (rdy2 && vld1_reg),
        .load_out      (rdy3 && vld2_reg),
        .gain_p        (gain_p_reg),
        .gain_i_dt     (gain_i_dt_reg),
        .gain_d_per_dt (gain_d_dt_reg),
        .err           (err_s1),
        .isum          (isum_s1),
        .diff          (diff_s1),
        .flags_in      (flags_s1),
        .command       (command),
        .flags_out     (flags_out)
    );

    // Pack the result word
    assign m_axis_tvalid = vld3_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-CMD_W-2){1'b0}}, flags_out.running,
                            flags_out.at_goal, command};
    assign m_axis_tuser  = flags_out.cmd_valid;

endmodule

>>> rtl/core/pidc_chk.sv
module pidc_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pidc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);
    import pidc_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // No command computed means a zero command
    a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[CMD_W-1:0] == '0)
        else $error("nonzero command without command_valid");

    // A computed command leaves the controller running
    a_cmd_running: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[CMD_W+1])
        else $error("command computed while stopped");

    // Goal reached and running never show together
    a_goal_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[CMD_W] && m_axis_tdata[CMD_W+1]))
        else $error("at_goal set while running");

endmodule

bind pid_controller_step_top pidc_chk u_pidc_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/sv/tb_pid_controller_step_top.sv
`timescale 1ns / 100ps

module tb_pid_controller_step_top;

    import pidc_pkg::*;

    // Codes the package enums leave out but the fields can carry
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    localparam int    GAIN_FRAC = 8;
    localparam int    MAX_WAIT  = 18;
    localparam longint CMD_MAX  = 64'sd2147483647;
    localparam longint CMD_MIN  = -64'sd2147483648;

    typedef struct {
        logic [CMD_W-1:0] command;
        logic             cmd_valid;
        logic             at_goal;
        logic             running;
    } pid_result_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [15:0]            s_axis_tdata = '0;    // measurement
    logic [KIND_W-1:0]      s_axis_tuser = '0;    // kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;         // command, at_goal, running
    logic                   m_axis_tuser;         // command_valid

    // Controller shadow: configuration and state
    longint         cfg_goal = 0;
    longint         cfg_gain_p = 0;
    longint         cfg_gain_i = 0;
    longint         cfg_gain_d = 0;
    longint         cfg_limit = 64'h0000_0000_00FF_FFFF;
    longint         cfg_band = 0;
    logic [1:0]     cfg_mode = MODE_ALWAYS;
    longint         ctl_integral = 0;
    longint         ctl_prev_error = 0;
    bit             ctl_running = 0;
    bit             ctl_at_goal = 0;

    pid_result_t    pending_results[$];
    int             mismatch_count = 0;
    bit             tx_quiet = 0;
    bit             rx_quiet = 0;
    int             rx_hold_cycles = 0;

    pid_controller_step_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the controller shadow by one word and return its result
    function automatic pid_result_t predict_pid_step(input logic [1:0] kind,
                                                     input logic [15:0] meas);
        pid_result_t res;
        longint      err;
        longint      mag;
        longint      acc;
        bit          in_band;
        res.command   = '0;
        res.cmd_valid = 1'b0;
        if (kind == KIND_ENABLE)
        begin
            ctl_running    = 1'b1;
            ctl_at_goal    = 1'b0;
            ctl_integral   = 0;
            ctl_prev_error = 0;
        end
        else if (kind == KIND_DISABLE)
        begin
            ctl_running = 1'b0;
        end
        else if (kind == KIND_SAMPLE && ctl_running)
        begin
            err     = cfg_goal - longint'($signed(meas));
            mag     = (err < 0) ? -err : err;
            in_band = (mag < cfg_band);
            if (cfg_mode == MODE_ALWAYS || !in_band)
            begin
                // accumulate and clamp the integral, then sum the three terms
                ctl_integral = ctl_integral + err;
                if (ctl_integral > cfg_limit)
                    ctl_integral = cfg_limit;
                if (ctl_integral < -cfg_limit)
                    ctl_integral = -cfg_limit;
                acc = cfg_gain_p * err + cfg_gain_i * ctl_integral
                    + cfg_gain_d * (err - ctl_prev_error);
                ctl_prev_error = err;
                acc = acc >>> GAIN_FRAC;
                if (acc > CMD_MAX)
                    acc = CMD_MAX;
                if (acc < CMD_MIN)
                    acc = CMD_MIN;
                res.command   = acc[31:0];
                res.cmd_valid = 1'b1;
            end
            else if (cfg_mode != MODE_SKIP)
            begin
                // stop at goal
                ctl_at_goal = 1'b1;
                ctl_running = 1'b0;
            end
        end
        res.at_goal = ctl_at_goal;
        res.running = ctl_running;
        return res;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ERROR: %s", $realtime, msg);
    endtask

    // Write one register while the block is idle and mirror it
    task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GOAL:      cfg_goal   = $signed(val[15:0]);
            REG_GAIN_P:    cfg_gain_p = $signed(val[15:0]);
            REG_GAIN_I_DT: cfg_gain_i = $signed(val[15:0]);
            REG_GAIN_D_DT: cfg_gain_d = $signed(val[15:0]);
            REG_INT_LIMIT: cfg_limit  = {40'd0, val};
            REG_GOAL_BAND: cfg_band   = {48'd0, val[15:0]};
            default:       cfg_mode   = val[1:0];
        endcase
        @(negedge clk);
    endtask

    // Offer one word, hold it until accepted, record its expected result
    task automatic send_word(input logic [1:0] kind, input logic [15:0] meas);
        int          gap;
        pid_result_t exp_res;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= meas;
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        exp_res = predict_pid_step(kind, meas);
        pending_results.push_back(exp_res);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain_results();
        int waited;
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            note_failure($sformatf("%0d results never arrived", pending_results.size()));
            mismatch_count += pending_results.size() - 1;
            pending_results.delete();
        end
        repeat (8) @(negedge clk);
    endtask

    // Measurement around the goal, on the band edges, or anywhere
    function automatic logic [15:0] pick_measurement();
        int     sel;
        longint off;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1:    off = longint'($urandom_range(0, 64)) - 32;
            2:       off = cfg_band;
            3:       off = -cfg_band;
            4:       off = cfg_band - 1;
            5:       off = 1 - cfg_band;
            6:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom());
        endcase
        return 16'(cfg_goal - off);
    endfunction

    function automatic logic [23:0] draw_reg_value(input cfg_reg_t idx);
        int sel;
        sel = $urandom_range(0, 3);
        case (idx)
            REG_GOAL:
                return (sel == 0) ? 24'h008000 : (sel == 1) ? 24'h007FFF
                                                            : 24'($urandom_range(0, 65535));
            REG_GAIN_P, REG_GAIN_I_DT, REG_GAIN_D_DT:
                if (sel == 0)
                    return $urandom_range(0, 1) ? 24'h008000 : 24'h007FFF;
                else if (sel == 1)
                    return {8'd0, 16'($urandom_range(0, 2048) - 1024)};
                else
                    return 24'($urandom_range(0, 65535));
            REG_INT_LIMIT:
                return (sel == 0) ? 24'hFFFFFF : (sel == 1) ? 24'($urandom_range(0, 3))
                     : (sel == 2) ? 24'($urandom_range(0, 4000)) : 24'($urandom());
            REG_GOAL_BAND:
                return (sel == 0) ? 24'd0 : (sel == 1) ? 24'h00FFFF
                                          : 24'($urandom_range(0, 600));
            default:
                return 24'($urandom_range(0, 3));
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
                stall = rx_hold_cycles;
            else
                stall = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            rx_hold_cycles = 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready) && rx_hold_cycles == 0);
            @(negedge clk);
        end
    end

    // Compare each accepted result word with the oldest expectation
    initial
    begin
        pid_result_t got;
        pid_result_t want;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.command   = m_axis_tdata[31:0];
                got.at_goal   = m_axis_tdata[32];
                got.running   = m_axis_tdata[33];
                got.cmd_valid = m_axis_tuser;
                if (pending_results.size() == 0)
                    note_failure("result word with no expectation waiting");
                else
                begin
                    want = pending_results.pop_front();
                    if (got.command !== want.command || got.cmd_valid !== want.cmd_valid
                        || got.at_goal !== want.at_goal || got.running !== want.running
                        || m_axis_tdata[OUT_DATA_W-1:34] !== '0)
                        note_failure({
                            $sformatf("exp cmd=%0d vld=%0b goal=%0b run=%0b",
                                      $signed(want.command), want.cmd_valid,
                                      want.at_goal, want.running),
                            $sformatf("  act cmd=%0d vld=%0b goal=%0b run=%0b pad=%h",
                                      $signed(got.command), got.cmd_valid,
                                      got.at_goal, got.running,
                                      m_axis_tdata[OUT_DATA_W-1:34])});
                end
            end
        end
    end

    // Defaults after reset: stopped controller, zero gains
    task automatic test_reset_defaults();
        send_word(KIND_SAMPLE, 16'h1234);
        send_word(KIND_RESERVED, 16'hFFFF);
        send_word(KIND_ENABLE, 16'h0000);
        send_word(KIND_SAMPLE, 16'h8000);
        drain_results();
    endtask

    // Field extremes, re-enable while running, disable, reserved kind
    task automatic test_directed_control();
        write_reg(REG_GOAL, 24'd1000);
        write_reg(REG_GAIN_P, 24'd256);
        write_reg(REG_GAIN_I_DT, 24'd128);
        write_reg(REG_GAIN_D_DT, 24'h00FF00);
        write_reg(REG_INT_LIMIT, 24'd3);
        send_word(KIND_ENABLE, 16'h0000);
        send_word(KIND_SAMPLE, 16'h8000);
        send_word(KIND_SAMPLE, 16'h7FFF);
        send_word(KIND_SAMPLE, 16'd1000);
        send_word(KIND_RESERVED, 16'h0000);
        send_word(KIND_ENABLE, 16'h0000);
        send_word(KIND_SAMPLE, 16'h0005);
        send_word(KIND_DISABLE, 16'h0000);
        send_word(KIND_SAMPLE, 16'h0005);
        drain_results();
    endtask

    // Band handling in each goal mode, edges of the band included
    task automatic test_goal_band_modes();
        write_reg(REG_GOAL, 24'd0);
        write_reg(REG_GOAL_BAND, 24'd50);
        write_reg(REG_GOAL_MODE, 24'(MODE_SKIP));
        send_word(KIND_ENABLE, 16'h0000);
        send_word(KIND_SAMPLE, 16'hFFCF);
        send_word(KIND_SAMPLE, 16'd50);
        drain_results();
        write_reg(REG_GOAL_MODE, 24'(MODE_STOP));
        send_word(KIND_SAMPLE, 16'd49);
        send_word(KIND_SAMPLE, 16'd400);
        drain_results();
        write_reg(REG_GOAL_MODE, 24'(MODE_RESERVED));
        send_word(KIND_ENABLE, 16'h0000);
        send_word(KIND_SAMPLE, 16'hFFFD);
        drain_results();
        write_reg(REG_GOAL_MODE, 24'(MODE_ALWAYS));
        send_word(KIND_ENABLE, 16'h0000);
        send_word(KIND_SAMPLE, 16'd3);
        drain_results();
    endtask

    // Drive the integral to its limit so the command saturates both ways
    task automatic test_integral_saturation();
        write_reg(REG_GAIN_P, 24'h007FFF);
        write_reg(REG_GAIN_I_DT, 24'h007FFF);
        write_reg(REG_GAIN_D_DT, 24'h007FFF);
        write_reg(REG_INT_LIMIT, 24'hFFFFFF);
        write_reg(REG_GOAL_BAND, 24'd0);
        write_reg(REG_GOAL, 24'h007FFF);
        send_word(KIND_ENABLE, 16'h0000);
        repeat (260) send_word(KIND_SAMPLE, 16'h8000);
        drain_results();
        write_reg(REG_GOAL, 24'h008000);
        send_word(KIND_ENABLE, 16'h0000);
        repeat (260) send_word(KIND_SAMPLE, 16'h7FFF);
        drain_results();
    endtask

    // Hold the master side off while words keep coming, so input stalls
    task automatic test_output_backpressure();
        write_reg(REG_GAIN_P, 24'd300);
        write_reg(REG_GAIN_I_DT, 24'd20);
        write_reg(REG_GAIN_D_DT, 24'h00FFA0);
        tx_quiet = 1'b1;
        send_word(KIND_ENABLE, 16'h0000);
        rx_hold_cycles = 400;
        repeat (60) send_word(KIND_SAMPLE, pick_measurement());
        tx_quiet = 1'b0;
        drain_results();
    endtask

    // All-high, all-low, then random settings; mostly enable-and-run sequences with some noise
    task automatic test_random_phases();
        int          phase;
        int          sent;
        int          run_len;
        int          r;
        cfg_reg_t    idx;
        logic [23:0] val;
        bit          hi;
        for (phase = 0; phase < 6; phase++)
        begin
            drain_results();
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            hi = (phase == 0);
            for (r = 0; r < 7; r++)
            begin
                idx = cfg_reg_t'(r);
                if (phase < 2)
                begin
                    // all-high then all-low settings
                    case (idx)
                        REG_INT_LIMIT: val = hi ? 24'hFFFFFF : 24'd0;
                        REG_GOAL_BAND: val = hi ? 24'h00FFFF : 24'd0;
                        REG_GOAL_MODE: val = hi ? 24'(MODE_RESERVED) : 24'(MODE_ALWAYS);
                        default:       val = hi ? 24'h007FFF : 24'h008000;
                    endcase
                end
                else
                    val = draw_reg_value(idx);
                write_reg(idx, val);
            end
            sent = 0;
            while (sent < 250)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    tx_quiet = ~tx_quiet;
                    rx_quiet = $urandom_range(0, 1);
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    send_word(2'($urandom_range(0, 3)), 16'($urandom()));
                    sent++;
                end
                else
                begin
                    send_word(KIND_ENABLE, 16'($urandom()));
                    sent++;
                    run_len = $urandom_range(4, 40);
                    repeat (run_len)
                    begin
                        if ($urandom_range(0, 29) == 0)
                            send_word($urandom_range(0, 1) ? KIND_DISABLE : KIND_RESERVED,
                                      16'($urandom()));
                        else
                            send_word(KIND_SAMPLE, pick_measurement());
                        sent++;
                    end
                end
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        drain_results();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_directed_control();
        test_goal_band_modes();
        test_integral_saturation();
        test_output_backpressure();
        test_random_phases();
        if (mismatch_count == 0)
            $display("tb_pid_controller_step_top OK");
        else
            $display("tb_pid_controller_step_top NOT OK");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #20_000_000;
        $display("tb_pid_controller_step_top NOT OK");
        $finish;
    end

endmodule
